/* hw/rtl/fdq_pkg.sv */
// ---------------------------------------------------------------------------
// fdq_pkg
// Shared types, constants and basis helper for the 8x8 forward DCT quantizer.
// ---------------------------------------------------------------------------
package fdq_pkg;

  // field and store widths
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 20;
  localparam int COEF_W   = 14;
  localparam int ROW_FRAC = 9;

  // defaults for the top level parameters
  localparam int COEF_FRAC_BITS_DEF = 3;
  localparam int COS_BITS_DEF       = 14;

  // reciprocal multiply for the quantizer divide
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 21;

  // cos(j*pi/16) scaled by 2^23
  localparam int COS_TAB [9] = '{
    8388608, 8227423, 7750063, 6974873, 5931642,
    4660461, 3210181, 1636536, 0
  };

  // luminance quantization table, row-major
  localparam logic [6:0] LUM_Q [64] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd57, 7'd80, 7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  // one sample moving down the cell chain
  typedef struct packed {
    logic             vld;
    logic [2:0]       n;
    logic [2:0]       tag;
    logic [ROW_W-1:0] data;
  } fdq_link_t;

  // write request into the row pass store
  typedef struct packed {
    logic             vld;
    logic [5:0]       addr;
    logic [ROW_W-1:0] data;
  } fdq_row_wr_t;

  // write request into the coefficient store
  typedef struct packed {
    logic              vld;
    logic [5:0]        addr;
    logic [COEF_W-1:0] data;
  } fdq_col_wr_t;

  // basis constant 0.5*c(k)*cos((2n+1)k*pi/16) with cos_bits fraction bits
  function automatic logic signed [19:0] basis(input logic [2:0] k, input logic [2:0] n,
                                               input int cos_bits);
    logic [4:0] m;
    logic [3:0] j;
    logic       neg;
    int         mag;
    m   = 5'({1'b0, n, 1'b1} * {2'b00, k});
    neg = 1'b0;
    if (k == 3'd0) begin
      j = 4'd4;
    end else if (m <= 5'd8) begin
      j = 4'(m);
    end else if (m <= 5'd16) begin
      j   = 4'(5'd16 - m);
      neg = 1'b1;
    end else if (m <= 5'd24) begin
      j   = 4'(m - 5'd16);
      neg = 1'b1;
    end else begin
      j = 4'(6'd32 - {1'b0, m});
    end
    mag = (COS_TAB[j] + (1 << (23 - cos_bits))) >> (24 - cos_bits);
    return neg ? 20'(-mag) : 20'(mag);
  endfunction

endpackage

/* hw/rtl/dct_8x8_forward_quantizer_unit.sv */
// ---------------------------------------------------------------------------
// dct_8x8_forward_quantizer_unit
// 8x8 forward DCT-II with optional quantization by a luminance table.
// ---------------------------------------------------------------------------
// Takes 64 pixels of one block in row-major order at one per cycle, then runs
// a row pass and a column pass through a chain of eight frequency cells, each
// pass streaming 64 samples through the chain and the rounding pipeline. It
// then drains 64 coefficients in row-major order, the last one marked. The
// drain reads a single-port coefficient store and reads the next coefficient
// only once the previous one has been taken. No new pixel is taken until the
// previous block has been fully drained. The quantize setting is sampled with
// the 64th pixel.
module dct_8x8_forward_quantizer_unit import fdq_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int COS_BITS       = COS_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [PIX_W-1:0]         pixel_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [COEF_W-1:0] coefficient_o,
  output logic                     last_o
);

  localparam int ACC_W = ROW_W + COS_BITS + 4;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROW,
    ST_COL,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic   qe_q, qe_lat_q;
  logic [5:0] ld_cnt_q;
  logic [6:0] fcnt_q, wcnt_q;
  logic [5:0] dcnt_q, rd_addr_q;
  logic       pend_q;
  logic       out_valid_q, out_last_q;
  logic [COEF_W-1:0] out_coef_q;
  logic       feed_vld_q;
  logic [2:0] feed_n_q, feed_tag_q;

  // stores
  logic [PIX_W-1:0]  pix_mem [64];
  logic [ROW_W-1:0]  row_mem [64];
  logic [COEF_W-1:0] out_mem [64];
  logic [PIX_W-1:0]  pix_rd_q;
  logic [ROW_W-1:0]  row_rd_q;
  logic [COEF_W-1:0] out_rd_q;

  logic in_acc, feeding, drain_issue;
  logic signed [PIX_W-1:0] pix_c;

  fdq_link_t   lnk [9];
  logic [7:0]  cell_done;
  logic [2:0]  cell_tag [8];
  logic signed [ACC_W-1:0] cell_acc [8];

  logic                    sel_vld;
  logic [2:0]              sel_k, sel_tag;
  logic signed [ACC_W-1:0] sel_acc;

  fdq_row_wr_t row_wr;
  fdq_col_wr_t col_wr;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_acc      = in_valid_i && in_ready_o;
  assign feeding     = ((state_q == ST_ROW) || (state_q == ST_COL)) && !fcnt_q[6];
  assign drain_issue = (state_q == ST_DRAIN) && !pend_q && !out_valid_q;

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      qe_q        <= 1'b0;
      qe_lat_q    <= 1'b0;
      ld_cnt_q    <= '0;
      fcnt_q      <= '0;
      wcnt_q      <= '0;
      dcnt_q      <= '0;
      rd_addr_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_coef_q  <= '0;
      feed_vld_q  <= 1'b0;
      feed_n_q    <= '0;
      feed_tag_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        qe_q <= cfg_data_i;
      end
      feed_vld_q <= feeding;
      feed_n_q   <= fcnt_q[2:0];
      feed_tag_q <= fcnt_q[5:3];
      if (feeding) begin
        fcnt_q <= fcnt_q + 7'd1;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            ld_cnt_q <= ld_cnt_q + 6'd1;
            if (ld_cnt_q == 6'd63) begin
              qe_lat_q <= qe_q;
              fcnt_q   <= '0;
              wcnt_q   <= '0;
              state_q  <= ST_ROW;
            end
          end
        end
        ST_ROW: begin
          if (row_wr.vld) begin
            wcnt_q <= wcnt_q + 7'd1;
          end
          if (wcnt_q[6]) begin
            fcnt_q  <= '0;
            wcnt_q  <= '0;
            state_q <= ST_COL;
          end
        end
        ST_COL: begin
          if (col_wr.vld) begin
            wcnt_q <= wcnt_q + 7'd1;
          end
          if (wcnt_q[6]) begin
            dcnt_q  <= '0;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_issue) begin
            rd_addr_q <= dcnt_q;
            dcnt_q    <= dcnt_q + 6'd1;
            pend_q    <= 1'b1;
          end
          if (pend_q) begin
            pend_q      <= 1'b0;
            out_valid_q <= 1'b1;
            out_coef_q  <= out_rd_q;
            out_last_q  <= (rd_addr_q == 6'd63);
          end
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= ST_LOAD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  // pixel store
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_mem[ld_cnt_q] <= pixel_i;
    end
    pix_rd_q <= pix_mem[fcnt_q[5:0]];
  end

  // row pass store, read column-wise during the column pass
  always_ff @(posedge clk_i) begin
    if (row_wr.vld) begin
      row_mem[row_wr.addr] <= row_wr.data;
    end
    row_rd_q <= row_mem[{fcnt_q[2:0], fcnt_q[5:3]}];
  end

  // coefficient store
  always_ff @(posedge clk_i) begin
    if (col_wr.vld) begin
      out_mem[col_wr.addr] <= col_wr.data;
    end
    if (drain_issue) begin
      out_rd_q <= out_mem[dcnt_q];
    end
  end

  // chain input: centered pixels or row pass results
  assign pix_c       = {~pix_rd_q[PIX_W-1], pix_rd_q[PIX_W-2:0]};
  assign lnk[0].vld  = feed_vld_q;
  assign lnk[0].n    = feed_n_q;
  assign lnk[0].tag  = feed_tag_q;
  assign lnk[0].data = (state_q == ST_COL) ? row_rd_q : ROW_W'(pix_c);

  // frequency cell chain
  for (genvar k = 0; k < 8; k++) begin : g_cell
    fdq_cell #(
      .K        (k),
      .COS_BITS (COS_BITS),
      .ACC_W    (ACC_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .link_i (lnk[k]),
      .link_o (lnk[k+1]),
      .done_o (cell_done[k]),
      .tag_o  (cell_tag[k]),
      .acc_o  (cell_acc[k])
    );
  end

  // at most one cell finishes per cycle
  always_comb begin
    sel_vld = 1'b0;
    sel_k   = '0;
    sel_tag = '0;
    sel_acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (cell_done[k]) begin
        sel_vld = 1'b1;
        sel_k   = 3'(k);
        sel_tag = cell_tag[k];
        sel_acc = cell_acc[k];
      end
    end
  end

  fdq_post #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .COS_BITS       (COS_BITS),
    .ACC_W          (ACC_W)
  ) u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .col_i    (state_q == ST_COL),
    .qe_i     (qe_lat_q),
    .vld_i    (sel_vld),
    .k_i      (sel_k),
    .tag_i    (sel_tag),
    .acc_i    (sel_acc),
    .row_wr_o (row_wr),
    .col_wr_o (col_wr)
  );

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = out_coef_q;
  assign last_o        = out_last_q;

  // checks
  a_one_cell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_done))
    else $error("more than one cell finished in a cycle");

  a_single_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(row_wr.vld && col_wr.vld))
    else $error("row and column writes collided");

  a_last_reopens_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("load not reopened after last coefficient");

  a_no_output_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("coefficient pending while loading pixels");

endmodule

/* hw/rtl/fdq_cell.sv */
// ---------------------------------------------------------------------------
// fdq_cell
// One frequency cell: multiply-accumulate of 8 samples, forwards each sample.
// ---------------------------------------------------------------------------
module fdq_cell import fdq_pkg::*; #(
  parameter int K        = 0,
  parameter int COS_BITS = COS_BITS_DEF,
  parameter int ACC_W    = ROW_W + COS_BITS_DEF + 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fdq_link_t               link_i,
  output fdq_link_t               link_o,
  output logic                    done_o,
  output logic [2:0]              tag_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int B_W = COS_BITS + 1;
  localparam int P_W = ROW_W + B_W;

  logic signed [B_W-1:0]   coef;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  fdq_link_t               link_q;
  logic                    done_q;
  logic [2:0]              tag_q;

  // basis for this frequency at the sample position
  assign coef = B_W'(basis(3'(K), link_i.n, COS_BITS));
  assign prod = $signed(link_i.data) * coef;

  // restart the sum on the first sample of a group
  always_comb begin
    if (link_i.n == 3'd0) begin
      acc_d = ACC_W'(prod);
    end else begin
      acc_d = acc_q + ACC_W'(prod);
    end
  end

  // forwarded sample and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
      done_q <= 1'b0;
    end else begin
      link_q <= link_i;
      done_q <= link_i.vld && (link_i.n == 3'd7);
    end
  end

  // running sum
  always_ff @(posedge clk_i) begin
    if (link_i.vld) begin
      acc_q <= acc_d;
      tag_q <= link_i.tag;
    end
  end

  assign link_o = link_q;
  assign done_o = done_q;
  assign tag_o  = tag_q;
  assign acc_o  = acc_q;

endmodule

/* hw/rtl/fdq_post.sv */
// ---------------------------------------------------------------------------
// fdq_post
// Rounding, saturation and quantization of cell sums into store writes.
// ---------------------------------------------------------------------------
module fdq_post import fdq_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int COS_BITS       = COS_BITS_DEF,
  parameter int ACC_W          = ROW_W + COS_BITS_DEF + 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    col_i,
  input  logic                    qe_i,
  input  logic                    vld_i,
  input  logic [2:0]              k_i,
  input  logic [2:0]              tag_i,
  input  logic signed [ACC_W-1:0] acc_i,
  output fdq_row_wr_t             row_wr_o,
  output fdq_col_wr_t             col_wr_o
);

  localparam int RS    = COS_BITS - ROW_FRAC;
  localparam int QSH   = ROW_FRAC + COS_BITS;
  localparam int CSH   = QSH - COEF_FRAC_BITS;
  localparam int NW    = ACC_W + 1 - QSH;
  localparam int PW    = NW + RECIP_W;
  localparam logic [ACC_W:0] RND_ROW = (ACC_W + 1)'(1) << (RS - 1);
  localparam logic [ACC_W:0] RND_RAW = (ACC_W + 1)'(1) << (CSH - 1);
  localparam logic [ACC_W:0] ROW_POS = (ACC_W + 1)'((1 << (ROW_W - 1)) - 1);
  localparam logic [ACC_W:0] ROW_NEG = (ACC_W + 1)'(1 << (ROW_W - 1));
  localparam logic [ACC_W:0] RAW_CAP = (ACC_W + 1)'(1 << (COEF_W - 1));
  localparam logic [PW-1:0]  OUT_POS = PW'((1 << (COEF_W - 1)) - 1);
  localparam logic [PW-1:0]  OUT_NEG = PW'(1 << (COEF_W - 1));

  // reciprocals of the table entries, exact for the numerator range
  logic [RECIP_W-1:0] recip [64];
  for (genvar i = 0; i < 64; i++) begin : g_recip
    localparam int unsigned RC =
      ((32'd1 << RECIP_SHIFT) + 32'(LUM_Q[i]) - 32'd1) / 32'(LUM_Q[i]);
    assign recip[i] = RECIP_W'(RC);
  end

  // stage 1: sign and magnitude
  logic             v1_q, neg1_q;
  logic [ACC_W-1:0] mag1_q;
  logic [5:0]       addr1_q;
  // stage 2
  logic              v2_q, neg2_q;
  logic [NW-1:0]     n2_q;
  logic [COEF_W-1:0] raw2_q;
  logic [5:0]        addr2_q;
  // stage 3
  logic              v3_q, neg3_q;
  logic [PW-1:0]     prod3_q;
  logic [COEF_W-1:0] raw3_q;
  logic [5:0]        addr3_q;
  // registered write requests
  fdq_row_wr_t row_wr_q;
  fdq_col_wr_t col_wr_q;

  // stage 2 arithmetic
  logic [ACC_W:0]    rsum, rmag, rclp, csum, cmag, nsum;
  logic [ROW_W-1:0]  rdata;
  // stage 4 arithmetic
  logic [PW-1:0]     qmag, smag, slim, sclp;
  logic [COEF_W-1:0] cdata;

  // row pass: round to row fraction bits and saturate
  always_comb begin
    rsum  = {1'b0, mag1_q} + RND_ROW;
    rmag  = rsum >> RS;
    if (neg1_q) begin
      rclp = (rmag > ROW_NEG) ? ROW_NEG : rmag;
    end else begin
      rclp = (rmag > ROW_POS) ? ROW_POS : rmag;
    end
    rdata = neg1_q ? ROW_W'(-rclp) : ROW_W'(rclp);
  end

  // column pass: raw rounding and quantizer numerator
  always_comb begin
    csum = {1'b0, mag1_q} + RND_RAW;
    cmag = csum >> CSH;
    cmag = (cmag > RAW_CAP) ? RAW_CAP : cmag;
    nsum = {1'b0, mag1_q} + ((ACC_W + 1)'(LUM_Q[addr1_q]) << (QSH - 1));
  end

  // quantized or raw magnitude, then signed saturation
  always_comb begin
    qmag  = prod3_q >> RECIP_SHIFT;
    smag  = qe_i ? qmag : PW'(raw3_q);
    slim  = neg3_q ? OUT_NEG : OUT_POS;
    sclp  = (smag > slim) ? slim : smag;
    cdata = neg3_q ? COEF_W'(-sclp) : COEF_W'(sclp);
  end

  // valid bits of the pipeline and write requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      row_wr_q <= '0;
      col_wr_q <= '0;
    end else begin
      v1_q          <= vld_i;
      v2_q          <= v1_q && col_i;
      v3_q          <= v2_q;
      row_wr_q.vld  <= v1_q && !col_i;
      row_wr_q.addr <= addr1_q;
      row_wr_q.data <= rdata;
      col_wr_q.vld  <= v3_q;
      col_wr_q.addr <= addr3_q;
      col_wr_q.data <= cdata;
    end
  end

  // payload of the pipeline
  always_ff @(posedge clk_i) begin
    neg1_q  <= acc_i[ACC_W-1];
    mag1_q  <= acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    addr1_q <= col_i ? {k_i, tag_i} : {tag_i, k_i};

    neg2_q  <= neg1_q;
    n2_q    <= NW'(nsum >> QSH);
    raw2_q  <= COEF_W'(cmag);
    addr2_q <= addr1_q;

    neg3_q  <= neg2_q;
    prod3_q <= PW'(n2_q) * PW'(recip[addr2_q]);
    raw3_q  <= raw2_q;
    addr3_q <= addr2_q;
  end

  assign row_wr_o = row_wr_q;
  assign col_wr_o = col_wr_q;

endmodule
